// File: rtl/rwle_pkg.sv
// Shared types and constants for the register write log encoder.
// No dependencies; compile first.
package rwle_pkg;

	localparam int POS_W  = 25;
	localparam int TIME_W = 32;
	localparam int BYTE_W = 8;
	localparam int WLEN_W = 3;

	localparam logic [POS_W-1:0] CAP_RESET = 25'd65536;

	// Stream command bytes
	localparam logic [BYTE_W-1:0] CMD_WAIT_ONE  = 8'hFF;
	localparam logic [BYTE_W-1:0] CMD_WAIT_LONG = 8'hFE;
	localparam logic [BYTE_W-1:0] CMD_END       = 8'hFD;
	localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h00;

	// Addresses that are logged even when unchanged
	localparam logic [7:0] ADDR_KEYON  = 8'h01;
	localparam logic [7:0] ADDR_NOISE  = 8'h08;
	localparam logic [7:0] ADDR_TIMER  = 8'h14;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_LOOP  = 2'd1,
		FUNC_END   = 2'd2,
		FUNC_BEGIN = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_PLAN,
		ST_WAIT,
		ST_BODY,
		ST_NONE
	} state_t;

	function automatic logic addr_listed(input logic [7:0] a);
		return a == 8'h01 || a == 8'h08 || (a >= 8'h0F && a <= 8'h12) ||
			a == 8'h14 || a == 8'h18 || a == 8'h19 || a == 8'h1B || a >= 8'h20;
	endfunction

endpackage

// File: rtl/rwle_ifs.sv
// Valid/ready channel interfaces: command requests, stream items, capacity writes.
// Depends on rwle_pkg.
interface rwle_cmd_if import rwle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	func_t                    func;
	logic [7:0]               reg_addr;
	logic [7:0]               reg_data;
	logic signed [TIME_W-1:0] event_time;

	modport source (output valid, func, reg_addr, reg_data, event_time, input ready);
	modport sink (input valid, func, reg_addr, reg_data, event_time, output ready);
endinterface

interface rwle_stream_if import rwle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              last;
	logic              reg_logged;
	logic [POS_W-1:0]  loop_offset;
	logic [POS_W-1:0]  bytes_used;

	modport source (output valid, out_byte, byte_valid, last, reg_logged, loop_offset,
		bytes_used, input ready);
	modport sink (input valid, out_byte, byte_valid, last, reg_logged, loop_offset,
		bytes_used, output ready);
endinterface

interface rwle_cfg_if import rwle_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] buffer_capacity;

	modport source (output valid, buffer_capacity, input ready);
	modport sink (input valid, buffer_capacity, output ready);
endinterface

// File: rtl/register_write_log_encoder.sv
// Register write log encoder: turns timestamped sound-chip register writes into a
// wait / write / end command byte stream. Depends on rwle_pkg and rwle_ifs.
//
// Use:
//  - cmd carries one request: register write, loop mark, end of dump or begin of
//    dump. A request is taken only while the sequencer is idle.
//  - stream returns one item per stream byte (wait header, varint digits, write
//    triple, end byte), or a single item with byte_valid low when a request emits
//    nothing. last marks the final item of a request.
//  - cfg writes buffer_capacity; write it only while no request is in flight.
// Sequence:
//  - after a request is taken, the lookup state filters the write against the shadow
//    entry read at accept, the plan state plans the wait and the fit checks, then the
//    byte sequencer emits one item per cycle while the output register is empty or taken.
//  - a request passes lookup, plan, its items, and idle, where the next request is
//    taken; a new request is not taken before the final item of the last has fired.
// Reset: shadow entries invalid, positions and times cleared, capacity 65536.
// Stall: a result waits in the output register; the sequencer holds until the
// receiver takes it, and the next request can enter while the final one waits.
module register_write_log_encoder import rwle_pkg::*; #(
	parameter int REG_COUNT = 256
) (
	input logic          clk,
	input logic          arst_n,
	rwle_cmd_if.sink     cmd,
	rwle_stream_if.source stream,
	rwle_cfg_if.sink     cfg
);

	localparam int AW = $clog2(REG_COUNT);

	// Sequencer state
	state_t state_q, state_d;

	// Architectural state
	logic [POS_W-1:0]  cap_q;
	logic [POS_W-1:0]  wp_q;
	logic [POS_W-1:0]  loop_q;
	logic              ended_q;
	logic [TIME_W-1:0] begin_q;
	logic [TIME_W-1:0] prev_q;

	// Shadow memory: data in a synchronous array, valid bits in flops
	logic [7:0]           shadow_mem [REG_COUNT];
	logic [7:0]           rdata_q;
	logic [REG_COUNT-1:0] shadow_vld_q;

	// Latched request
	func_t             func_q;
	logic [7:0]        addr_q;
	logic [7:0]        data_q;
	logic [TIME_W-1:0] t_q;

	// Per-request plan
	logic              logged_q;
	logic              act_q;
	logic [TIME_W-1:0] d_q;
	logic [30:0]       n_q;
	logic              single_q;
	logic              first_q;
	logic [WLEN_W-1:0] wait_cnt_q;
	logic [1:0]        body_cnt_q;

	// Output register
	logic              out_vld_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              obv_q;
	logic              olast_q;
	logic              ologged_q;
	logic [POS_W-1:0]  oloop_q;
	logic [POS_W-1:0]  oused_q;

	// Combinational
	logic              cmd_fire;
	logic              slot_free;
	logic              fire;
	logic [BYTE_W-1:0] fire_byte;
	logic              fire_bv;
	logic              fire_last;
	logic              listed, same, special, logged;
	logic              sh_we;
	logic              end_act;
	logic [WLEN_W-1:0] wlen;
	logic [POS_W:0]    wp_ext, cap_ext;
	logic [POS_W:0]    wait_sum, body_with, body_none;
	logic [2:0]        body_need;
	logic              wait_fit, wait_go, body_go;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	// Filter in the lookup cycle: read data of the shadow entry is ready now
	always_comb begin
		listed  = addr_listed(addr_q);
		same    = shadow_vld_q[addr_q[AW-1:0]] && (rdata_q == data_q);
		special = addr_q == ADDR_KEYON || addr_q == ADDR_NOISE || addr_q == ADDR_TIMER;
		logged  = func_q == FUNC_WRITE && listed && (!same || special);
		sh_we   = state_q == ST_LOOK && logged;
		end_act = func_q == FUNC_END && wp_q != '0 && !ended_q;
	end

	// Plan: wait length from the delta, then the fit checks against capacity
	always_comb begin
		wlen = '0;
		if (d_q == 32'd1) begin
			wlen = 3'd1;
		end else if (!d_q[31] && d_q >= 32'd2) begin
			priority if (d_q < 32'd130) begin
				wlen = 3'd2;
			end else if (d_q < 32'd16386) begin
				wlen = 3'd3;
			end else if (d_q < 32'd2097154) begin
				wlen = 3'd4;
			end else if (d_q < 32'd268435458) begin
				wlen = 3'd5;
			end else begin
				wlen = 3'd6;
			end
		end
		wp_ext    = {1'b0, wp_q};
		cap_ext   = {1'b0, cap_q};
		body_need = (func_q == FUNC_WRITE) ? 3'd4 : 3'd1;
		wait_sum  = wp_ext + (POS_W+1)'(wlen) + (POS_W+1)'(1);
		body_with = wp_ext + (POS_W+1)'(wlen) + (POS_W+1)'(body_need);
		body_none = wp_ext + (POS_W+1)'(body_need);
		wait_fit  = wait_sum <= cap_ext;
		wait_go   = act_q && wlen != '0 && wait_fit;
		body_go   = act_q && ((wait_go ? body_with : body_none) <= cap_ext);
	end

	// Byte sequencer outputs
	always_comb begin
		cmd.ready = state_q == ST_IDLE;
		slot_free = !out_vld_q || stream.ready;
		fire      = 1'b0;
		fire_byte = '0;
		fire_bv   = 1'b0;
		fire_last = 1'b0;
		unique case (state_q)
			ST_WAIT: begin
				fire    = slot_free;
				fire_bv = 1'b1;
				if (first_q) begin
					fire_byte = single_q ? CMD_WAIT_ONE : CMD_WAIT_LONG;
				end else begin
					fire_byte = {|n_q[30:7], n_q[6:0]};
				end
				fire_last = wait_cnt_q == WLEN_W'(1) && body_cnt_q == '0;
			end
			ST_BODY: begin
				fire    = slot_free;
				fire_bv = 1'b1;
				priority if (func_q == FUNC_END) begin
					fire_byte = CMD_END;
				end else if (body_cnt_q == 2'd3) begin
					fire_byte = CMD_WRITE;
				end else if (body_cnt_q == 2'd2) begin
					fire_byte = addr_q;
				end else begin
					fire_byte = data_q;
				end
				fire_last = body_cnt_q == 2'd1;
			end
			ST_NONE: begin
				fire      = slot_free;
				fire_last = 1'b1;
			end
			ST_IDLE, ST_LOOK, ST_PLAN: begin
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_fire) state_d = ST_LOOK;
			ST_LOOK: state_d = ST_PLAN;
			ST_PLAN: begin
				if (wait_go) state_d = ST_WAIT;
				else if (body_go) state_d = ST_BODY;
				else state_d = ST_NONE;
			end
			ST_WAIT: begin
				if (fire && wait_cnt_q == WLEN_W'(1))
					state_d = (body_cnt_q != '0) ? ST_BODY : ST_IDLE;
			end
			ST_BODY: if (fire && body_cnt_q == 2'd1) state_d = ST_IDLE;
			ST_NONE: if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Shadow memory: read at accept, write back in the lookup cycle.
	// Requests are serialized, so a read never overlaps a pending write.
	always_ff @(posedge clk) begin
		if (cmd_fire) rdata_q <= shadow_mem[cmd.reg_addr[AW-1:0]];
		if (sh_we) shadow_mem[addr_q[AW-1:0]] <= data_q;
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_RESET;
			wp_q         <= '0;
			loop_q       <= '0;
			ended_q      <= 1'b0;
			begin_q      <= '0;
			prev_q       <= '0;
			shadow_vld_q <= '0;
			out_vld_q    <= 1'b0;
			wait_cnt_q   <= '0;
			body_cnt_q   <= '0;
			first_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) cap_q <= cfg.buffer_capacity;

			if (sh_we) shadow_vld_q[addr_q[AW-1:0]] <= 1'b1;

			if (state_q == ST_LOOK) begin
				unique case (func_q)
					FUNC_WRITE: begin
					end
					FUNC_LOOP: begin
						loop_q       <= wp_q;
						shadow_vld_q <= '0;
					end
					FUNC_END: begin
						if (end_act) ended_q <= 1'b1;
					end
					FUNC_BEGIN: begin
						begin_q      <= t_q;
						prev_q       <= t_q;
						shadow_vld_q <= '0;
						wp_q         <= '0;
						loop_q       <= '0;
						ended_q      <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			if (state_q == ST_PLAN) begin
				// advance time for an acted request unless it went backwards or the wait did not fit
				if (act_q && !d_q[31] && (wlen == '0 || wait_fit)) prev_q <= t_q;
				wait_cnt_q <= wait_go ? wlen : '0;
				first_q    <= 1'b1;
				if (body_go) body_cnt_q <= (func_q == FUNC_WRITE) ? 2'd3 : 2'd1;
				else body_cnt_q <= '0;
			end

			if (fire) begin
				if (fire_bv) wp_q <= wp_q + POS_W'(1);
				if (state_q == ST_WAIT) begin
					wait_cnt_q <= wait_cnt_q - WLEN_W'(1);
					first_q    <= 1'b0;
				end
				if (state_q == ST_BODY) body_cnt_q <= body_cnt_q - 2'd1;
			end

			if (fire) out_vld_q <= 1'b1;
			else if (stream.ready) out_vld_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			func_q <= cmd.func;
			addr_q <= cmd.reg_addr;
			data_q <= cmd.reg_data;
			t_q    <= cmd.event_time;
		end
		if (state_q == ST_LOOK) begin
			logged_q <= logged;
			act_q    <= logged || end_act;
			// leading silence after begin counts as no wait
			d_q      <= (prev_q == begin_q) ? '0 : t_q - prev_q;
		end
		if (state_q == ST_PLAN) begin
			n_q      <= 31'(d_q - 32'd2);
			single_q <= d_q == 32'd1;
		end
		if (fire && state_q == ST_WAIT && !first_q) n_q <= n_q >> 7;
		if (fire) begin
			obyte_q   <= fire_byte;
			obv_q     <= fire_bv;
			olast_q   <= fire_last;
			ologged_q <= logged_q;
			oloop_q   <= loop_q;
			oused_q   <= fire_bv ? wp_q + POS_W'(1) : wp_q;
		end
	end

	assign stream.valid       = out_vld_q;
	assign stream.out_byte    = obyte_q;
	assign stream.byte_valid  = obv_q;
	assign stream.last        = olast_q;
	assign stream.reg_logged  = ologged_q;
	assign stream.loop_offset = oloop_q;
	assign stream.bytes_used  = oused_q;

	// A wait byte is only emitted while the write position is below capacity
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fire_bv && state_q == ST_WAIT |-> wp_q < cap_q)
		else $error("wait byte emitted without room");

	// The final item of a request returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fire_last |=> state_q == ST_IDLE)
		else $error("sequencer busy after last item");

	// The wait phase always has bytes left to emit
	a_wait_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> wait_cnt_q != '0)
		else $error("wait phase with empty count");

	// A logged write leaves its shadow entry valid
	a_shadow_vld: assert property (@(posedge clk) disable iff (!arst_n)
		sh_we |=> shadow_vld_q[$past(addr_q[AW-1:0])])
		else $error("shadow entry not marked valid");

	// No request is taken while one is in flight
	a_serial: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd.ready ##1 !cmd.ready)
		else $error("request accepted during processing");

endmodule

// File: sim/register_write_log_encoder_test.sv
// Self-checking testbench for register_write_log_encoder: random and directed requests,
// a scoreboard that predicts every stream item, random stalls on both channels.
// Depends on rwle_pkg, rwle_ifs and the encoder RTL.
module register_write_log_encoder_test import rwle_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_LINES   = 100;

	// One stream item as seen on the output channel
	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic              reg_logged;
		logic [POS_W-1:0]  loop_offset;
		logic [POS_W-1:0]  bytes_used;
	} stream_item_t;

	// Scoreboard: mirrors the encoder state, turns each accepted request into the
	// stream items it must produce, and compares returned items in order.
	class stream_book;
		logic [POS_W-1:0] capacity;
		logic [POS_W-1:0] write_pos;
		logic [POS_W-1:0] loop_pt;
		logic [31:0]      begin_time;
		logic [31:0]      last_tick;
		bit               ended;
		bit               shadow_ok [256];
		logic [7:0]       shadow_val [256];
		stream_item_t     want_q [$];
		stream_item_t     staged [$];
		int               errors;
		int               seen;

		function new();
			capacity   = CAP_RESET;
			write_pos  = '0;
			loop_pt    = '0;
			begin_time = '0;
			last_tick  = '0;
			ended      = 0;
			errors     = 0;
			seen       = 0;
			clear_shadow();
		endfunction

		function void clear_shadow();
			foreach (shadow_ok[i]) begin
				shadow_ok[i]  = 0;
				shadow_val[i] = '0;
			end
		endfunction

		function void set_capacity(logic [POS_W-1:0] c);
			capacity = c;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// Addresses that the log keeps at all
		function bit addr_kept(logic [7:0] a);
			case (a)
				8'h01, 8'h08, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h14, 8'h18, 8'h19, 8'h1B: return 1;
				default: return a >= 8'h20;
			endcase
		endfunction

		// Room for k more bytes with the end byte still in reserve
		function bit has_room(int k);
			return longint'(write_pos) + k + 1 <= longint'(capacity);
		endfunction

		function void stage(logic [BYTE_W-1:0] b);
			stream_item_t it;
			write_pos      = write_pos + 1'b1;
			it.out_byte    = b;
			it.byte_valid  = 1'b1;
			it.last        = 1'b0;
			it.reg_logged  = 1'b0;
			it.loop_offset = loop_pt;
			it.bytes_used  = write_pos;
			staged.push_back(it);
		endfunction

		// Wait since the previous time; a wait that does not fit is dropped whole
		// and the previous time is held.
		function void stage_wait(logic [31:0] t);
			logic [31:0] ticks, n, v;
			int          len;
			bit          more;
			ticks = t - last_tick;
			if (last_tick == begin_time)
				ticks = '0;
			if (ticks == 32'd1) begin
				if (!has_room(1))
					return;
				stage(CMD_WAIT_ONE);
			end else if (ticks >= 32'd2 && !ticks[31]) begin
				n   = ticks - 32'd2;
				len = 2;
				v   = n >> 7;
				while (v != 0) begin
					len++;
					v = v >> 7;
				end
				if (!has_room(len))
					return;
				stage(CMD_WAIT_LONG);
				more = 1;
				while (more) begin
					more = (n >> 7) != 0;
					stage({more, n[6:0]});
					n = n >> 7;
				end
			end
			if (!ticks[31])
				last_tick = t;
		endfunction

		// Predict the items of one accepted request; return 1 unless it was dropped
		function bit note_request(func_t f, logic [7:0] a, logic [7:0] d, logic [31:0] t);
			stream_item_t it;
			bit           logged;
			logged = 0;
			staged.delete();
			case (f)
				FUNC_WRITE: begin
					if (addr_kept(a) && (!(shadow_ok[a] && shadow_val[a] == d) ||
							a == ADDR_KEYON || a == ADDR_NOISE || a == ADDR_TIMER)) begin
						shadow_ok[a]  = 1;
						shadow_val[a] = d;
						logged = 1;
						stage_wait(t);
						if (has_room(3)) begin
							stage(CMD_WRITE);
							stage(a);
							stage(d);
						end
					end
				end
				FUNC_LOOP: begin
					loop_pt = write_pos;
					clear_shadow();
				end
				FUNC_END: begin
					if (write_pos != 0 && !ended) begin
						stage_wait(t);
						if (longint'(write_pos) + 1 <= longint'(capacity))
							stage(CMD_END);
						ended = 1;
					end
				end
				default: begin
					begin_time = t;
					last_tick  = t;
					clear_shadow();
					write_pos = '0;
					loop_pt   = '0;
					ended     = 0;
				end
			endcase
			if (staged.size() == 0) begin
				it.out_byte    = '0;
				it.byte_valid  = 1'b0;
				it.last        = 1'b1;
				it.reg_logged  = logged;
				it.loop_offset = loop_pt;
				it.bytes_used  = write_pos;
				want_q.push_back(it);
			end else begin
				staged[staged.size()-1].last = 1'b1;
				foreach (staged[i]) begin
					staged[i].reg_logged = logged;
					want_q.push_back(staged[i]);
				end
			end
			return logged || f != FUNC_WRITE;
		endfunction

		task report(string msg);
			if (errors < MAX_LINES)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_item(stream_item_t got);
			stream_item_t want;
			seen++;
			if (want_q.size() == 0) begin
				report($sformatf("item %0d: byte=%02h valid=%b with nothing expected",
					seen, got.out_byte, got.byte_valid));
				return;
			end
			want = want_q.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.last !== want.last || got.reg_logged !== want.reg_logged ||
					got.loop_offset !== want.loop_offset || got.bytes_used !== want.bytes_used)
				report($sformatf({"item %0d: got %02h/%b/%b/%b/%0d/%0d, ",
					"want %02h/%b/%b/%b/%0d/%0d (byte/valid/last/logged/loop/used)"},
					seen, got.out_byte, got.byte_valid, got.last, got.reg_logged,
					got.loop_offset, got.bytes_used, want.out_byte, want.byte_valid,
					want.last, want.reg_logged, want.loop_offset, want.bytes_used));
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rwle_cmd_if    cmd_ch ();
	rwle_stream_if out_ch ();
	rwle_cfg_if    cfg_ch ();

	register_write_log_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.stream (out_ch),
		.cfg    (cfg_ch)
	);

	stream_book  book;
	int unsigned cmd_gap_max = 12;  // longest idle gap before a request
	int unsigned out_gap_max = 12;  // longest stall before taking a stream item
	int unsigned hold_cycles = 0;   // nonzero: sink holds ready low this long
	bit          out_hold    = 0;
	int unsigned cycle_count = 0;

	// Addresses that get past the filter or are logged even when unchanged
	logic [7:0] hot_addr [10] = '{8'h01, 8'h08, 8'h14, 8'h0F, 8'h12, 8'h18, 8'h19,
		8'h1B, 8'h20, 8'hFF};

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Long sink hold-off, counted here so the sender keeps offering requests and
	// the encoder backs up into its input.
	initial begin : sink_hold
		forever begin
			wait (hold_cycles > 0);
			out_hold = 1;
			repeat (hold_cycles) @(negedge clk);
			out_hold = 0;
			wait (hold_cycles == 0);
		end
	end

	// Stream sink: stall at random, take one item per handshake, check it
	initial begin : stream_sink
		int unsigned  stall;
		stream_item_t got;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, out_gap_max);
			if (stall != 0 || out_hold) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (out_hold) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.out_byte    = out_ch.out_byte;
			got.byte_valid  = out_ch.byte_valid;
			got.last        = out_ch.last;
			got.reg_logged  = out_ch.reg_logged;
			got.loop_offset = out_ch.loop_offset;
			got.bytes_used  = out_ch.bytes_used;
			book.check_item(got);
			@(negedge clk);
		end
	end

	// Offer one request after a random gap; return at the next falling edge with
	// valid still high so a back-to-back request keeps it up.
	task automatic send_request(input func_t f, input logic [7:0] a, input logic [7:0] d,
			input logic [31:0] t, output bit busy);
		int unsigned gap;
		gap = $urandom_range(0, cmd_gap_max);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.func       <= f;
		cmd_ch.reg_addr   <= a;
		cmd_ch.reg_data   <= d;
		cmd_ch.event_time <= t;
		do @(posedge clk); while (!cmd_ch.ready);
		busy = book.note_request(f, a, d, t);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted item has come back
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [POS_W-1:0] c);
		wait_idle();
		cfg_ch.valid           <= 1'b1;
		cfg_ch.buffer_capacity <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		book.set_capacity(c);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed dumps: a begin, then writes on a moving clock with
	// small and large waits, some loop marks and ends; a few backward or
	// scrambled times and fully random requests as noise. Dropped writes do
	// not count toward the target.
	task automatic run_random(input int target);
		int          done, r, q;
		bit          busy;
		logic [7:0]  a, d;
		logic [31:0] t;
		done = 0;
		t    = $urandom;
		send_request(FUNC_BEGIN, 8'($urandom), 8'($urandom), t, busy);
		while (done < target) begin
			r = $urandom_range(0, 99);
			a = $urandom_range(0, 1) ? hot_addr[4'($urandom_range(0, 9))] : 8'($urandom);
			d = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			if (r < 80) begin
				q = $urandom_range(0, 99);
				if (q < 30)
					t = t;
				else if (q < 50)
					t = t + 32'd1;
				else if (q < 62)
					t = t + 32'd2;
				else if (q < 82)
					t = t + $urandom_range(3, 400);
				else if (q < 90)
					t = t + $urandom_range(0, 32'h7FFF_FFFF);
				else if (q < 96)
					t = t - $urandom_range(1, 1000);
				else
					t = $urandom;
				send_request(FUNC_WRITE, a, d, t, busy);
			end else if (r < 85) begin
				send_request(FUNC_LOOP, a, d, t, busy);
			end else if (r < 90) begin
				t = t + $urandom_range(0, 3);
				send_request(FUNC_END, a, d, t, busy);
			end else if (r < 95) begin
				t = $urandom;
				send_request(FUNC_BEGIN, a, d, t, busy);
			end else begin
				t = $urandom;
				send_request(func_t'($urandom_range(0, 3)), a, d, t, busy);
			end
			if (busy)
				done++;
		end
	endtask

	initial begin : stimulus
		logic [31:0] tt;
		bit          busy;
		cmd_ch.valid           = 1'b0;
		cmd_ch.func            = FUNC_WRITE;
		cmd_ch.reg_addr        = '0;
		cmd_ch.reg_data        = '0;
		cmd_ch.event_time      = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.buffer_capacity = '0;
		book = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset capacity.
		// Leading silence from reset, then an unchanged write and an unlisted one.
		send_request(FUNC_WRITE, 8'h20, 8'h00, 32'd0, busy);
		send_request(FUNC_WRITE, 8'h20, 8'h00, 32'd5, busy);
		send_request(FUNC_WRITE, 8'h13, 8'hAA, 32'd5, busy);
		// End once, then a second end that must do nothing
		send_request(FUNC_END, 8'h00, 8'h00, 32'd5, busy);
		send_request(FUNC_END, 8'h00, 8'h00, 32'd9, busy);
		// Begin, and an end on an empty stream
		send_request(FUNC_BEGIN, 8'hFF, 8'hFF, 32'd100, busy);
		send_request(FUNC_END, 8'h00, 8'h00, 32'd100, busy);
		// Always-logged addresses repeated; one-tick wait, varint of 0, 127, 128
		send_request(FUNC_WRITE, 8'h08, 8'hFF, 32'd100, busy);
		send_request(FUNC_WRITE, 8'h01, 8'h80, 32'd150, busy);
		send_request(FUNC_WRITE, 8'h01, 8'h80, 32'd151, busy);
		send_request(FUNC_WRITE, 8'h08, 8'hFF, 32'd153, busy);
		send_request(FUNC_WRITE, 8'h14, 8'h00, 32'd282, busy);
		send_request(FUNC_WRITE, 8'h14, 8'h00, 32'd412, busy);
		// Longest wait: five varint digits
		tt = 32'd412 + 32'h7FFF_FFFF;
		send_request(FUNC_WRITE, 8'h0F, 8'h01, tt, busy);
		// Time going backwards, and a difference of exactly half the range
		send_request(FUNC_WRITE, 8'h12, 8'h02, tt - 32'd1000, busy);
		send_request(FUNC_WRITE, 8'h18, 8'h03, tt + 32'h8000_0000, busy);
		send_request(FUNC_WRITE, 8'h1F, 8'h04, tt, busy);
		send_request(FUNC_WRITE, 8'h00, 8'h05, tt, busy);
		// Loop mark forgets the shadow, so an unchanged value is logged again
		send_request(FUNC_LOOP, 8'h00, 8'h00, tt, busy);
		send_request(FUNC_WRITE, 8'h12, 8'h02, tt, busy);
		send_request(FUNC_END, 8'h00, 8'h00, tt + 32'd3, busy);
		send_request(FUNC_WRITE, 8'h19, 8'hFF, tt + 32'd4, busy);
		// Tight buffer: triple fits, then neither wait nor triple, then end alone
		set_capacity(25'd5);
		send_request(FUNC_BEGIN, 8'h00, 8'h00, 32'd0, busy);
		send_request(FUNC_WRITE, 8'h1B, 8'h11, 32'd1, busy);
		send_request(FUNC_WRITE, 8'h20, 8'h22, 32'd301, busy);
		send_request(FUNC_END, 8'h00, 8'h00, 32'd302, busy);

		// Largest buffer, random gaps on both sides
		set_capacity(25'h100_0000);
		run_random(60);

		// Sink holds off while requests keep coming back to back
		set_capacity(25'($urandom_range(1000, 70000)));
		cmd_gap_max = 0;
		hold_cycles = 300;
		run_random(40);
		hold_cycles = 0;
		cmd_gap_max = 12;

		// Smallest buffer, then small ones that fill up quickly
		set_capacity(25'd2);
		run_random(10);
		set_capacity(25'($urandom_range(5, 60)));
		run_random(40);

		// Random capacity, no idling on either side
		set_capacity(25'($urandom_range(2, 25'h100_0000)));
		cmd_gap_max = 0;
		out_gap_max = 0;
		run_random(40);

		// Drain, then let any stray item show up before the verdict
		wait_idle();
		repeat (20) @(negedge clk);
		if (book.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
